// ----- sv/sbc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, widths and codes for the shape bounding box containment unit.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int COORD_W   = 32;
    localparam int TOL_W     = 16;
    localparam int KIND_W    = 2;
    localparam int S_DATA_W  = 6 * COORD_W;
    localparam int S_USER_W  = 1 + KIND_W;
    localparam int M_DATA_W  = 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    localparam logic ROLE_STORE = 1'b0;
    localparam logic ROLE_TEST  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_POINT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CIRCLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic   role;
        coord_t lox;
        coord_t loy;
        coord_t hix;
        coord_t hiy;
    } sbc_entry_t;

    // saturate a sum that carries one extra bit
    function automatic coord_t sat_sum(input logic signed [COORD_W:0] v);
        coord_t r;
        r = v[COORD_W-1:0];
        if (v[COORD_W] != v[COORD_W-1]) begin
            r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/sbc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_front
// Reduces one incoming shape beat to its axis-aligned bounding box.
// ----------------------------------------------------------------------------
module sbc_front (
    input  wire logic                          role,
    input  wire logic [sbc_pkg::KIND_W-1:0]    shape_kind,
    input  wire logic [sbc_pkg::S_DATA_W-1:0]  coords,
    output sbc_pkg::sbc_entry_t                entry
);
    import sbc_pkg::*;

    coord_t ax, ay, bx, by, cx, cy;
    coord_t min_x, min_y, max_x, max_y;

    assign ax = coords[0*COORD_W +: COORD_W];
    assign ay = coords[1*COORD_W +: COORD_W];
    assign bx = coords[2*COORD_W +: COORD_W];
    assign by = coords[3*COORD_W +: COORD_W];
    assign cx = coords[4*COORD_W +: COORD_W];
    assign cy = coords[5*COORD_W +: COORD_W];

    always_comb begin
        min_x = (ax < bx) ? ax : bx;
        min_x = (min_x < cx) ? min_x : cx;
        min_y = (ay < by) ? ay : by;
        min_y = (min_y < cy) ? min_y : cy;
        max_x = (ax > bx) ? ax : bx;
        max_x = (max_x > cx) ? max_x : cx;
        max_y = (ay > by) ? ay : by;
        max_y = (max_y > cy) ? max_y : cy;
    end

    always_comb begin
        entry.role = role;
        unique case (shape_kind)
            KIND_POINT: begin
                entry.lox = ax;
                entry.loy = ay;
                entry.hix = ax;
                entry.hiy = ay;
            end
            KIND_CIRCLE: begin
                entry.lox = sat_sum({ax[COORD_W-1], ax} - {bx[COORD_W-1], bx});
                entry.loy = sat_sum({ay[COORD_W-1], ay} - {bx[COORD_W-1], bx});
                entry.hix = sat_sum({ax[COORD_W-1], ax} + {bx[COORD_W-1], bx});
                entry.hiy = sat_sum({ay[COORD_W-1], ay} + {bx[COORD_W-1], bx});
            end
            KIND_RECT: begin
                entry.lox = ax;
                entry.loy = ay;
                entry.hix = sat_sum({ax[COORD_W-1], ax} + {bx[COORD_W-1], bx});
                entry.hiy = sat_sum({ay[COORD_W-1], ay} + {by[COORD_W-1], by});
            end
            KIND_TRIANGLE: begin
                entry.lox = min_x;
                entry.loy = min_y;
                entry.hix = max_x;
                entry.hiy = max_y;
            end
            default: begin
                entry.lox = ax;
                entry.loy = ay;
                entry.hix = ax;
                entry.hiy = ay;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/sbc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_queue
// Short in-order queue of classified boxes between front and back.
// ----------------------------------------------------------------------------
module sbc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire sbc_pkg::sbc_entry_t push_entry,
    output logic               full,
    output logic               head_valid,
    output sbc_pkg::sbc_entry_t head_entry,
    input  wire logic          pop
);
    import sbc_pkg::*;

    sbc_entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]     count_reg, count_next;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        logic [Q_AW-1:0] r;
        r = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == Q_CW'(1) && pop && !push) |=> !head_valid)
        else $error("queue not empty after last pop");

endmodule
`default_nettype wire

// ----- sv/sbc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sbc_back
// Holds the enclosing box, tests queued boxes against it, drives results.
// ----------------------------------------------------------------------------
module sbc_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [sbc_pkg::TOL_W-1:0]   tolerance,
    input  wire logic                        head_valid,
    input  wire sbc_pkg::sbc_entry_t         head_entry,
    output logic                             pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [sbc_pkg::M_DATA_W-1:0]     m_tdata
);
    import sbc_pkg::*;

    coord_t box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic   box_present_reg;
    logic   valid_reg, valid_next;
    logic   encloses_reg, encloses_next;
    logic   no_box_reg, no_box_next;
    logic   out_free;
    logic   is_store;
    logic   contained;

    // a beyond b on the low side, or within tolerance: a < b, or a - b < tolerance
    function automatic logic side_ok(input coord_t a, input coord_t b,
                                     input logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] || (d[COORD_W-1:0] < COORD_W'(tol));
    endfunction

    assign out_free = !valid_reg || m_tready;
    assign is_store = (head_entry.role == ROLE_STORE);
    assign pop      = head_valid && (is_store || out_free);

    assign contained = side_ok(box_min_x_reg, head_entry.lox, tolerance)
                    && side_ok(box_min_y_reg, head_entry.loy, tolerance)
                    && side_ok(head_entry.hix, box_max_x_reg, tolerance)
                    && side_ok(head_entry.hiy, box_max_y_reg, tolerance);

    always_comb begin
        valid_next    = valid_reg;
        encloses_next = encloses_reg;
        no_box_next   = no_box_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (pop && !is_store) begin
            valid_next    = 1'b1;
            encloses_next = box_present_reg && contained;
            no_box_next   = !box_present_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            box_present_reg <= 1'b0;
            box_min_x_reg   <= '0;
            box_min_y_reg   <= '0;
            box_max_x_reg   <= '0;
            box_max_y_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            if (pop && is_store) begin
                box_present_reg <= 1'b1;
                box_min_x_reg   <= head_entry.lox;
                box_min_y_reg   <= head_entry.loy;
                box_max_x_reg   <= head_entry.hix;
                box_max_y_reg   <= head_entry.hiy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        encloses_reg <= encloses_next;
        no_box_reg   <= no_box_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-2){1'b0}}, no_box_reg, encloses_reg};

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(encloses_reg && no_box_reg)) else $error("both flags set");
    a_box_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(box_present_reg)) else $error("stored box lost");
    a_no_box_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !is_store && box_present_reg) |=> !no_box_reg)
        else $error("missing-box flag with stored box");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !is_store) |-> out_free) else $error("result overwritten");

endmodule
`default_nettype wire

// ----- sv/shape_bbox_containment_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shape_bbox_containment_unit
// Bounding box containment test for point, circle, rectangle and triangle
// shapes in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one shape beat per cycle while s_tready is high. A role-0 beat stores
// its bounding box as the enclosing box and produces no result; a role-1 beat
// raises m_tvalid after passing the queue and the output register (the box
// reduction is combinational and lands in the two-entry queue at the accepting
// edge; the compare stage then loads the output register). The sustained rate
// is one beat per cycle while m_tready stays high. While a result waits, the
// queue takes two more beats before s_tready drops; s_tready then rises once a
// pop is registered. Write the tolerance only while no beat is in flight.
module shape_bbox_containment_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // coord_a_x, coord_a_y, coord_b_x, coord_b_y, coord_c_x, coord_c_y
    input  wire logic [sbc_pkg::S_DATA_W-1:0]  s_tdata,
    // role, shape_kind
    input  wire logic [sbc_pkg::S_USER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // encloses, no_enclosing_box, zero fill
    output logic [sbc_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sbc_pkg::TOL_W-1:0]     cfg_data
);
    import sbc_pkg::*;

    logic [TOL_W-1:0] tolerance_reg;
    sbc_entry_t       front_entry;
    sbc_entry_t       head_entry;
    logic             q_full;
    logic             head_valid;
    logic             pop;
    logic             push;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= TOL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tolerance_reg <= cfg_data;
        end
    end

    sbc_front u_front (
        .role       (s_tuser[0]),
        .shape_kind (s_tuser[KIND_W:1]),
        .coords     (s_tdata),
        .entry      (front_entry)
    );

    sbc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    sbc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tolerance  (tolerance_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/shape_bbox_containment_checker.sv -----
// ----------------------------------------------------------------------------
// shape_bbox_containment_checker
// Watches the shape, result and tolerance channels of the containment unit.
// Every accepted shape beat is reduced to its bounding box. A store beat
// replaces the enclosing box; a test beat queues the expected verdict. Result
// beats are compared in order against that queue. The failure count and the
// number of outstanding verdicts go back to the testbench top.
// ----------------------------------------------------------------------------
module shape_bbox_containment_checker
    import sbc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TOL_W-1:0]    cfg_data,
    output int                  fail_count,
    output int                  pending
);

    localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;

    typedef struct {
        longint lo_x;
        longint lo_y;
        longint hi_x;
        longint hi_y;
    } bbox_t;

    typedef struct packed {
        logic encloses;
        logic no_box;
    } verdict_t;

    bbox_t      enclosing_box;
    logic       have_box;
    longint     tol;
    verdict_t   verdict_q[$];
    int         errors;

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic bbox_t shape_bbox(input logic [KIND_W-1:0] kind,
                                         input logic [S_DATA_W-1:0] data);
        bbox_t  b;
        longint ax, ay, bx, by, cx, cy;
        ax = coord_t'(data[0*COORD_W +: COORD_W]);
        ay = coord_t'(data[1*COORD_W +: COORD_W]);
        bx = coord_t'(data[2*COORD_W +: COORD_W]);
        by = coord_t'(data[3*COORD_W +: COORD_W]);
        cx = coord_t'(data[4*COORD_W +: COORD_W]);
        cy = coord_t'(data[5*COORD_W +: COORD_W]);
        case (kind)
            KIND_POINT: begin
                b = '{ax, ay, ax, ay};
            end
            KIND_CIRCLE: begin
                b = '{clamp_coord(ax - bx), clamp_coord(ay - bx),
                      clamp_coord(ax + bx), clamp_coord(ay + bx)};
            end
            KIND_RECT: begin
                b = '{ax, ay, clamp_coord(ax + bx), clamp_coord(ay + by)};
            end
            default: begin
                b.lo_x = (ax < bx) ? ax : bx;
                b.lo_x = (b.lo_x < cx) ? b.lo_x : cx;
                b.lo_y = (ay < by) ? ay : by;
                b.lo_y = (b.lo_y < cy) ? b.lo_y : cy;
                b.hi_x = (ax > bx) ? ax : bx;
                b.hi_x = (b.hi_x > cx) ? b.hi_x : cx;
                b.hi_y = (ay > by) ? ay : by;
                b.hi_y = (b.hi_y > cy) ? b.hi_y : cy;
            end
        endcase
        return b;
    endfunction

    // outer lies strictly beyond inner on the low side, or within tolerance
    function automatic logic side_clear(input longint outer, input longint inner);
        if (outer < inner) return 1'b1;
        return (outer - inner) < tol;
    endfunction

    function automatic verdict_t containment_verdict(input bbox_t inner);
        verdict_t v;
        if (!have_box) begin
            v = '{encloses: 1'b0, no_box: 1'b1};
        end else begin
            v.no_box   = 1'b0;
            v.encloses = side_clear(enclosing_box.lo_x, inner.lo_x) &&
                         side_clear(enclosing_box.lo_y, inner.lo_y) &&
                         side_clear(inner.hi_x, enclosing_box.hi_x) &&
                         side_clear(inner.hi_y, enclosing_box.hi_y);
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        bbox_t    b;
        if (!aresetn) begin
            enclosing_box = '{0, 0, 0, 0};
            have_box      = 1'b0;
            tol           = longint'(TOL_RESET);
            verdict_q.delete();
            errors        = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no verdict outstanding: m_tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.encloses) begin
                        $error("encloses: expected %0d, actual %0d", want.encloses, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[1] !== want.no_box) begin
                        $error("no_enclosing_box: expected %0d, actual %0d",
                               want.no_box, m_tdata[1]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                b = shape_bbox(s_tuser[KIND_W:1], s_tdata);
                if (s_tuser[0] == ROLE_STORE) begin
                    enclosing_box = b;
                    have_box      = 1'b1;
                end else begin
                    verdict_q.push_back(containment_verdict(b));
                end
            end
            if (cfg_valid && cfg_ready) begin
                tol = longint'(cfg_data);
            end
        end
        fail_count <= errors;
        pending    <= verdict_q.size();
    end

endmodule

// ----- tb/tb_shape_bbox_containment_unit.sv -----
// ----------------------------------------------------------------------------
// tb_shape_bbox_containment_unit
// Stimulus and verdict for the shape bounding box containment unit.
// A directed pass covers the missing enclosing box, exact fits, tolerance
// edges, saturated sums and inverted boxes; random phases then run the
// tolerance through its extremes with some near-box shapes, random idling
// on both channels, one stretch with no idling and one long result hold-off.
// A checker module beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_shape_bbox_containment_unit;
    import sbc_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     HOLD_CYCLES    = 80;
    localparam int     PHASE_BEATS    = 95;
    localparam coord_t ONE            = 32'sh0001_0000;
    localparam coord_t C_MAX          = 32'sh7fff_ffff;
    localparam coord_t C_MIN          = 32'sh8000_0000;

    typedef enum int {RX_FREE, RX_STALL, RX_HOLD} rx_mode_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TOL_W-1:0]    cfg_data;
    int                  fail_count;
    int                  pending;

    rx_mode_t            rx_mode = RX_STALL;
    logic                tx_gaps = 1'b1;
    logic                have_store = 1'b0;
    logic [KIND_W-1:0]   last_kind;
    coord_t              last_f[6];
    int                  idle_cycles = 0;

    shape_bbox_containment_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    shape_bbox_containment_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic coord_t near_coord(input int span);
        return coord_t'($urandom_range(0, 2 * span * ONE)) - coord_t'(span * ONE);
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 5))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return C_MIN + 1;
            3:       return C_MAX - 1;
            4:       return '0;
            default: return -1;
        endcase
    endfunction

    task automatic send_shape(input logic role, input logic [KIND_W-1:0] kind,
                              input coord_t ax, input coord_t ay, input coord_t bx,
                              input coord_t by, input coord_t cx, input coord_t cy);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 1)) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cy, cx, by, bx, ay, ax};
        s_tuser  <= {kind, role};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input logic test_only);
        logic              role;
        logic [KIND_W-1:0] kind;
        coord_t            f[6];
        int                sel;
        role = (!test_only && $urandom_range(0, 99) < 20) ? ROLE_STORE : ROLE_TEST;
        kind = KIND_W'($urandom_range(0, 3));
        sel  = $urandom_range(0, 99);
        if (role == ROLE_TEST && sel < 30 && have_store) kind = last_kind;
        for (int i = 0; i < 6; i++) begin
            if (role == ROLE_TEST && sel < 30 && have_store)
                f[i] = last_f[i] + coord_t'($urandom_range(0, 400)) - 200;
            else if (sel < 80)
                f[i] = near_coord(role == ROLE_STORE ? 200 : 50);
            else if (sel < 90)
                f[i] = coord_t'($urandom);
            else
                f[i] = extreme_coord();
        end
        if (role == ROLE_STORE) begin
            have_store = 1'b1;
            last_kind  = kind;
            last_f     = f;
        end
        send_shape(role, kind, f[0], f[1], f[2], f[3], f[4], f[5]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side: free-running, random stalls, or one long hold-off
    initial begin
        forever begin
            if (rx_mode == RX_HOLD) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_mode = RX_STALL;
            end else if (rx_mode == RX_STALL && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_shape_bbox_containment_unit failed");
                $finish;
            end
        end
    end

    initial begin
        logic [TOL_W-1:0] tol_set[5];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no enclosing box yet
        send_shape(ROLE_TEST, KIND_POINT, 0, 0, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_TRIANGLE, C_MIN, C_MAX, C_MAX, C_MIN, -1, 0);
        // ten by ten square, default tolerance
        send_shape(ROLE_STORE, KIND_RECT, 0, 0, 10 * ONE, 10 * ONE, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, 5 * ONE, 5 * ONE, C_MAX, C_MIN, -1, 1);
        send_shape(ROLE_TEST, KIND_POINT, 0, 0, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, 10 * ONE + 65, 0, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, 10 * ONE + 66, 0, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_CIRCLE, 5 * ONE, 5 * ONE, 5 * ONE, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_CIRCLE, 5 * ONE, 5 * ONE, 6 * ONE, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_TRIANGLE, ONE, ONE, 9 * ONE, 2 * ONE, 5 * ONE, 9 * ONE);
        send_shape(ROLE_TEST, KIND_TRIANGLE, ONE, -ONE, 9 * ONE, 2 * ONE, 5 * ONE, 9 * ONE);
        send_shape(ROLE_TEST, KIND_RECT, 0, 0, 10 * ONE, 10 * ONE, 0, 0);
        send_shape(ROLE_TEST, KIND_RECT, 5 * ONE, 5 * ONE, -2 * ONE, -2 * ONE, 0, 0);
        // saturated sums and inverted boxes
        send_shape(ROLE_STORE, KIND_CIRCLE, 0, 0, C_MAX, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, C_MIN, C_MIN, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_RECT, C_MAX, C_MAX, C_MAX, C_MAX, 0, 0);
        send_shape(ROLE_STORE, KIND_CIRCLE, C_MIN, C_MIN, C_MAX, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, C_MIN, -ONE, 0, 0, 0, 0);
        send_shape(ROLE_STORE, KIND_RECT, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, 0, 0, 0, 0, 0, 0);
        send_shape(ROLE_STORE, KIND_TRIANGLE, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0);
        send_shape(ROLE_TEST, KIND_TRIANGLE, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0);
        send_shape(ROLE_TEST, KIND_CIRCLE, 0, 0, C_MIN, 0, 0, 0);
        // identical copy against zero and full tolerance
        send_shape(ROLE_STORE, KIND_POINT, 3 * ONE, -3 * ONE, 0, 0, 0, 0);
        wait_idle();
        write_tolerance(16'd0);
        send_shape(ROLE_TEST, KIND_POINT, 3 * ONE, -3 * ONE, 0, 0, 0, 0);
        wait_idle();
        write_tolerance(16'hffff);
        send_shape(ROLE_TEST, KIND_POINT, 3 * ONE + 65534, -3 * ONE, 0, 0, 0, 0);
        send_shape(ROLE_TEST, KIND_POINT, 3 * ONE + 65535, -3 * ONE, 0, 0, 0, 0);

        tol_set = '{16'd0, 16'hffff, 16'd1, TOL_W'($urandom_range(2, 65534)), TOL_RESET};
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_tolerance(tol_set[p]);
            rx_mode = (p == 1) ? RX_FREE : RX_STALL;
            tx_gaps = (p != 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 2 && n == 30) begin
                    rx_mode = RX_HOLD;
                    repeat (30) send_random(1'b1);
                end
                send_random(1'b0);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("tb_shape_bbox_containment_unit passed");
        else
            $display("tb_shape_bbox_containment_unit failed");
        $finish;
    end

endmodule
